FILE: hdl/cmsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmsd_pkg;

    // sample limits
    localparam int MAX_SAMPLES = 1024;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 34;
    localparam int SQS_W    = 56;
    localparam int PROD_W   = 2 * SAMPLE_W;

    // iterative unit
    localparam int DIV_STEPS  = SQS_W;
    localparam int ROOT_STEPS = SQS_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int DEN_W      = CNT_W + 1;
    localparam int REM_W      = DEN_W;
    localparam int ALU_W      = SQS_W + 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       last_of_column;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] column_mean;
        logic [SAMPLE_W-1:0]        column_std_dev;
        logic                       count_overflow;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hdl/cmsd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cmsd_in_if;
    logic               valid;
    logic               ready;
    cmsd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/cmsd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cmsd_out_if;
    logic                valid;
    logic                ready;
    cmsd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/column_mean_and_std_dev.sv
`timescale 1ns / 1ps
`default_nettype none

// Column statistics: samples of one column arrive one transfer at a time as signed
// Q8.16 values, the final one marked by last_of_column. Each sample is accepted,
// squared on the shared multiplier and accumulated. Up to MAX_SAMPLES samples
// are accumulated; further ones only raise count_overflow. On the marked sample the
// block emits one result: the mean (rounded to nearest, ties away from zero) and the
// population standard deviation floor(sqrt(floor(sumsq/n) - mean^2)), clamped at
// zero and saturated to 24 bits; an empty column gives zeros. Otherwise, after the
// column end and before the result is offered: a setup state, then one shared
// compare/subtract unit runs a 56-step restoring divide for the mean and a 56-step
// divide for the mean square, the multiplier squares the mean, the variance is
// formed and the square root runs 28 steps. The result is held until taken; the
// next sample is accepted after.

module column_mean_and_std_dev (
    input  wire             i_clk,
    input  wire             i_rst_n,
    cmsd_in_if.sink         i_in,
    cmsd_out_if.source      o_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQR, S_ACC, S_FIN, S_DIVM, S_DIVV, S_MSQ, S_VAR, S_ROOT, S_OUT
    } t_state;

    t_state r_state;

    // accumulators
    logic signed [cmsd_pkg::SUM_W-1:0] r_sum;
    logic [cmsd_pkg::SQS_W-1:0]        r_sqs;
    logic [cmsd_pkg::CNT_W-1:0]        r_count;
    logic                              r_ovf_seen;

    // sample in work
    logic [cmsd_pkg::SAMPLE_W-1:0]     r_x;
    logic [cmsd_pkg::SAMPLE_W-1:0]     r_mag;
    logic                              r_last;

    // shared unit state
    logic [cmsd_pkg::PROD_W-1:0]       r_prod;
    logic [cmsd_pkg::SQS_W-1:0]        r_quo;
    logic [cmsd_pkg::REM_W-1:0]        r_rem;
    logic [cmsd_pkg::DEN_W-1:0]        r_den;
    logic [cmsd_pkg::STEP_W-1:0]       r_step;
    logic [cmsd_pkg::SAMPLE_W-1:0]     r_mmag;
    logic                              r_neg;
    logic [cmsd_pkg::SQS_W-1:0]        r_rad;
    logic [cmsd_pkg::ALU_W-1:0]        r_root;
    logic [cmsd_pkg::SQS_W-1:0]        r_bit;

    // result register
    logic                              r_ovalid;
    cmsd_pkg::t_out_item               r_odata;

    // combinational helpers
    logic [cmsd_pkg::SAMPLE_W-1:0]     mul_op;
    logic [cmsd_pkg::PROD_W-1:0]       mul_res;
    logic [cmsd_pkg::ALU_W-1:0]        alu_a;
    logic [cmsd_pkg::ALU_W-1:0]        alu_b;
    logic [cmsd_pkg::ALU_W:0]          alu_diff;
    logic                              alu_borrow;
    logic                              q_bit;
    logic [cmsd_pkg::SQS_W-1:0]        quo_next;
    logic [cmsd_pkg::REM_W-1:0]        rem_next;
    logic [cmsd_pkg::ALU_W-1:0]        root_next;
    logic [cmsd_pkg::SQS_W:0]          sqs_sum;
    logic [cmsd_pkg::SUM_W-1:0]        smag;
    logic [cmsd_pkg::SUM_W:0]          mean_num;
    logic [cmsd_pkg::SAMPLE_W-1:0]     in_mag;
    logic [cmsd_pkg::SAMPLE_W-1:0]     mean_mag;
    logic [cmsd_pkg::SAMPLE_W-1:0]     sd_sat;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // magnitude of the incoming sample
    assign in_mag = i_in.data.sample_value[cmsd_pkg::SAMPLE_W-1]
                    ? cmsd_pkg::SAMPLE_W'(-i_in.data.sample_value)
                    : cmsd_pkg::SAMPLE_W'(i_in.data.sample_value);

    // shared squarer
    assign mul_op  = (r_state == S_SQR) ? r_mag : r_mmag;
    assign mul_res = cmsd_pkg::PROD_W'(mul_op) * cmsd_pkg::PROD_W'(mul_op);

    // shared compare/subtract unit
    always_comb begin
        unique case (r_state)
            S_DIVM, S_DIVV: begin
                alu_a = cmsd_pkg::ALU_W'({r_rem, r_quo[cmsd_pkg::SQS_W-1]});
                alu_b = cmsd_pkg::ALU_W'(r_den);
            end
            S_VAR: begin
                alu_a = {1'b0, r_quo};
                alu_b = cmsd_pkg::ALU_W'(r_prod);
            end
            S_ROOT: begin
                alu_a = {1'b0, r_rad};
                alu_b = r_root + {1'b0, r_bit};
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
        alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
        alu_borrow = alu_diff[cmsd_pkg::ALU_W];
    end

    // divider step
    assign q_bit    = ~alu_borrow;
    assign quo_next = {r_quo[cmsd_pkg::SQS_W-2:0], q_bit};
    assign rem_next = q_bit ? alu_diff[cmsd_pkg::REM_W-1:0]
                            : {r_rem[cmsd_pkg::REM_W-2:0], r_quo[cmsd_pkg::SQS_W-1]};
    assign mean_mag = quo_next[cmsd_pkg::SAMPLE_W-1:0];

    // root step and saturation
    assign root_next = alu_borrow ? (r_root >> 1)
                                  : ((r_root >> 1) + {1'b0, r_bit});
    assign sd_sat = (|root_next[cmsd_pkg::ALU_W-1:cmsd_pkg::SAMPLE_W])
                    ? '1 : root_next[cmsd_pkg::SAMPLE_W-1:0];

    // saturating square sum
    assign sqs_sum = {1'b0, r_sqs} + (cmsd_pkg::SQS_W + 1)'(r_prod);

    // rounded-mean numerator: 2*|sum| + n
    assign smag     = r_sum[cmsd_pkg::SUM_W-1] ? cmsd_pkg::SUM_W'(-r_sum)
                                               : cmsd_pkg::SUM_W'(r_sum);
    assign mean_num = {smag, 1'b0} + (cmsd_pkg::SUM_W + 1)'(r_count);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sum      <= '0;
            r_sqs      <= '0;
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x    <= i_in.data.sample_value;
                        r_mag  <= in_mag;
                        r_last <= i_in.data.last_of_column;
                        if (32'(r_count) < cmsd_pkg::MAX_SAMPLES) begin
                            r_state <= S_SQR;
                        end else begin
                            r_ovf_seen <= 1'b1;
                            r_state    <= i_in.data.last_of_column ? S_FIN : S_IDLE;
                        end
                    end
                end
                S_SQR: begin
                    r_prod  <= mul_res;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum   <= r_sum + {{(cmsd_pkg::SUM_W - cmsd_pkg::SAMPLE_W)
                                         {r_x[cmsd_pkg::SAMPLE_W-1]}}, r_x};
                    r_sqs   <= sqs_sum[cmsd_pkg::SQS_W] ? '1
                                                        : sqs_sum[cmsd_pkg::SQS_W-1:0];
                    r_count <= r_count + 1'b1;
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    // empty column gives zero outputs
                    if (r_count == '0) begin
                        r_odata.column_mean    <= '0;
                        r_odata.column_std_dev <= '0;
                        r_odata.count_overflow <= r_ovf_seen;
                        r_ovalid               <= 1'b1;
                        r_state                <= S_OUT;
                    end else begin
                        r_neg   <= r_sum[cmsd_pkg::SUM_W-1];
                        r_quo   <= cmsd_pkg::SQS_W'(mean_num);
                        r_rem   <= '0;
                        r_den   <= {r_count, 1'b0};
                        r_step  <= cmsd_pkg::STEP_W'(cmsd_pkg::DIV_STEPS - 1);
                        r_state <= S_DIVM;
                    end
                end
                S_DIVM: begin
                    if (r_step == '0) begin
                        // mean done, start sumsq / n
                        r_mmag  <= mean_mag;
                        r_quo   <= r_sqs;
                        r_rem   <= '0;
                        r_den   <= cmsd_pkg::DEN_W'(r_count);
                        r_step  <= cmsd_pkg::STEP_W'(cmsd_pkg::DIV_STEPS - 1);
                        r_state <= S_DIVV;
                    end else begin
                        r_quo  <= quo_next;
                        r_rem  <= rem_next;
                        r_step <= r_step - 1'b1;
                    end
                end
                S_DIVV: begin
                    r_quo <= quo_next;
                    r_rem <= rem_next;
                    if (r_step == '0) begin
                        r_state <= S_MSQ;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_MSQ: begin
                    r_prod  <= mul_res;
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    // clamp negative variance to zero
                    r_rad   <= alu_borrow ? '0 : alu_diff[cmsd_pkg::SQS_W-1:0];
                    r_root  <= '0;
                    r_bit   <= cmsd_pkg::SQS_W'(1) << (cmsd_pkg::SQS_W - 2);
                    r_step  <= cmsd_pkg::STEP_W'(cmsd_pkg::ROOT_STEPS - 1);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (!alu_borrow) begin
                        r_rad <= alu_diff[cmsd_pkg::SQS_W-1:0];
                    end
                    r_root <= root_next;
                    r_bit  <= r_bit >> 2;
                    if (r_step == '0) begin
                        r_odata.column_mean    <= r_neg ? cmsd_pkg::SAMPLE_W'(-r_mmag)
                                                        : r_mmag;
                        r_odata.column_std_dev <= sd_sat;
                        r_odata.count_overflow <= r_ovf_seen;
                        r_ovalid               <= 1'b1;
                        r_state                <= S_OUT;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_OUT: begin
                    // result transfer clears the column
                    if (o_out.ready) begin
                        r_ovalid   <= 1'b0;
                        r_sum      <= '0;
                        r_sqs      <= '0;
                        r_count    <= '0;
                        r_ovf_seen <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
